>>> rtl/bes_pkg.sv
`default_nettype none

package bes_pkg;

   localparam int COORD_BITS  = 24;
   localparam int T_FRAC_BITS = 16;
   localparam int T_BITS      = T_FRAC_BITS + 2;
   localparam int OUT_BITS    = COORD_BITS + 3;
   localparam int PROD_BITS   = COORD_BITS + T_FRAC_BITS + 3;
   localparam int MAX_WORDS   = 8;
   localparam int WORD_BITS   = $clog2(MAX_WORDS);

   typedef enum logic [2:0] {
      OP_QUAD_EVAL   = 3'd0,
      OP_QUAD_DERIV  = 3'd1,
      OP_QUAD_SPLIT  = 3'd2,
      OP_CUBIC_EVAL  = 3'd3,
      OP_CUBIC_DERIV = 3'd4,
      OP_CUBIC_SPLIT = 3'd5
   } op_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [OUT_BITS-1:0]   out_coord_type;
   typedef logic signed [T_BITS-1:0]     param_type;
   typedef logic [T_FRAC_BITS:0]         tval_type;
   typedef logic [WORD_BITS-1:0]         word_idx_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      out_coord_type x;
      out_coord_type y;
   } vec_type;

   typedef struct packed {
      out_coord_type x;
      out_coord_type y;
      logic          half;
      logic [1:0]    index;
   } word_type;

   // t limited to 0 .. 2^T_FRAC_BITS
   function automatic tval_type clamp_t(param_type t);
      tval_type r;
      if (t[T_BITS-1]) begin
         r = '0;
      end else if (t[T_FRAC_BITS]) begin
         r = tval_type'(1) << T_FRAC_BITS;
      end else begin
         r = {1'b0, t[T_FRAC_BITS-1:0]};
      end
      return r;
   endfunction

   // a + floor((b - a) * t / 2^T_FRAC_BITS); the result stays between a and b
   function automatic coord_type lerp_coord(coord_type a, coord_type b, tval_type t);
      logic signed [COORD_BITS:0]  diff;
      logic signed [PROD_BITS-1:0] prod;
      logic signed [COORD_BITS:0]  step;
      logic signed [COORD_BITS:0]  sum;
      diff = (COORD_BITS+1)'(b) - (COORD_BITS+1)'(a);
      prod = PROD_BITS'(diff) * PROD_BITS'($signed({1'b0, t}));
      step = (COORD_BITS+1)'(prod >>> T_FRAC_BITS);
      sum  = (COORD_BITS+1)'(a) + step;
      return COORD_BITS'(sum);
   endfunction

   function automatic point_type lerp_point(point_type a, point_type b, tval_type t);
      point_type r;
      r.x = lerp_coord(a.x, b.x, t);
      r.y = lerp_coord(a.y, b.y, t);
      return r;
   endfunction

   // 2*(b-a) or 3*(b-a)
   function automatic out_coord_type tangent_axis(coord_type a, coord_type b, logic triple);
      out_coord_type d;
      out_coord_type r;
      d = OUT_BITS'(b) - OUT_BITS'(a);
      if (triple) begin
         r = d + (d <<< 1);
      end else begin
         r = d <<< 1;
      end
      return r;
   endfunction

   function automatic word_type make_word(point_type p, logic half, logic [1:0] index);
      word_type w;
      w.x     = OUT_BITS'(p.x);
      w.y     = OUT_BITS'(p.y);
      w.half  = half;
      w.index = index;
      return w;
   endfunction

endpackage

`default_nettype wire

>>> rtl/bes_channel_if.sv
`default_nettype none

interface bes_req_if
   import bes_pkg::*;
();
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   coord_type  p0_x;
   coord_type  p0_y;
   coord_type  p1_x;
   coord_type  p1_y;
   coord_type  p2_x;
   coord_type  p2_y;
   coord_type  p3_x;
   coord_type  p3_y;
   param_type  param_t;

   modport source (
      output valid, req_type, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, param_t,
      input  ready
   );
   modport sink (
      input  valid, req_type, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, param_t,
      output ready
   );
endinterface

interface bes_rsp_if
   import bes_pkg::*;
();
   logic          valid;
   logic          ready;
   out_coord_type out_x;
   out_coord_type out_y;
   logic          curve_half;
   logic [1:0]    point_index;
   logic          last_point;

   modport source (
      output valid, out_x, out_y, curve_half, point_index, last_point,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, curve_half, point_index, last_point,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/bezier_eval_split_unit.sv
// Quadratic / cubic Bezier evaluate, tangent and split unit.
// req_chan takes one request word: operation, four signed Q16.8 control
// points and a Q1.16 parameter t (clamped to 0..1). rsp_chan returns result
// words: one point or tangent for eval/derivative, 6 (quadratic) or 8 (cubic)
// control points for split, left sub-curve first. last_point marks the final
// word of a request. Requests with an unknown operation give no words.
// A request accepted on req_chan passes the input register, then the first,
// second and third lerp level and the output queue, in that order, before
// its first word shows on rsp_chan.
// Throughput: one request per cycle for eval and derivative while rsp_chan
// is ready; a split holds the output register until its 6 or 8 words are
// taken, and the pipeline behind it keeps filling meanwhile. The output word
// rate is set by the output register, which sends one word at a time.
// Receiver stall: every stage holds its word while the next one is full and
// stalled; req_chan.ready drops once all four stages and the output are full.
// Nothing is lost or repeated.
// Reset (synchronous, active high) clears all stage valid bits; ready is high
// in the first cycle after reset.
`default_nettype none

module bezier_eval_split_unit
   import bes_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   bes_req_if.sink    req_chan,
   bes_rsp_if.source  rsp_chan
);

   // stage 1: captured request
   logic      s1_vld_ff;
   op_type    s1_op_ff;
   point_type s1_p_ff [4];
   tval_type  s1_t_ff;
   logic      s1_vld_in;
   logic      s1_rdy;

   // stage 2: first lerp level
   logic      s2_vld_ff;
   op_type    s2_op_ff;
   tval_type  s2_t_ff;
   point_type s2_p0_ff, s2_p2_ff, s2_p3_ff;
   point_type s2_q0_ff, s2_q1_ff, s2_q2_ff;
   logic      s2_rdy;

   // stage 3: second lerp level
   logic      s3_vld_ff;
   op_type    s3_op_ff;
   tval_type  s3_t_ff;
   point_type s3_p0_ff, s3_p2_ff, s3_p3_ff;
   point_type s3_q0_ff, s3_q1_ff, s3_q2_ff;
   point_type s3_r0_ff, s3_r1_ff;
   logic      s3_rdy;

   // stage 4: mid point and tangent
   logic      s4_vld_ff;
   op_type    s4_op_ff;
   point_type s4_p0_ff, s4_p2_ff, s4_p3_ff;
   point_type s4_q0_ff, s4_q1_ff, s4_q2_ff;
   point_type s4_r0_ff, s4_r1_ff, s4_mid_ff;
   vec_type   s4_tan_ff;
   vec_type   s4_tan_in;
   logic      s4_rdy;

   // output queue
   logic         ser_vld_ff;
   word_type     ser_words_ff [MAX_WORDS];
   word_idx_type ser_cnt_ff;
   word_idx_type ser_end_ff;
   word_type     ser_words_in [MAX_WORDS];
   word_idx_type ser_end_in;
   word_type     ser_word;
   logic         ser_last;
   logic         ser_pop;
   logic         ser_free;
   logic         triple;

   assign ser_last = (ser_cnt_ff == ser_end_ff);
   assign ser_pop  = ser_vld_ff && rsp_chan.ready;
   assign ser_free = !ser_vld_ff || (ser_pop && ser_last);
   assign s4_rdy   = !s4_vld_ff || ser_free;
   assign s3_rdy   = !s3_vld_ff || s4_rdy;
   assign s2_rdy   = !s2_vld_ff || s3_rdy;
   assign s1_rdy   = !s1_vld_ff || s2_rdy;

   assign req_chan.ready = s1_rdy;
   // unknown operations are dropped at the door
   assign s1_vld_in = req_chan.valid && (req_chan.req_type <= OP_CUBIC_SPLIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         ser_vld_ff <= 1'b0;
         ser_cnt_ff <= '0;
      end else begin
         if (s1_rdy) begin
            s1_vld_ff <= s1_vld_in;
         end
         if (s2_rdy) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_rdy) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (s4_rdy) begin
            s4_vld_ff <= s3_vld_ff;
         end
         if (ser_free) begin
            ser_vld_ff <= s4_vld_ff;
            ser_cnt_ff <= '0;
         end else if (ser_pop) begin
            ser_cnt_ff <= ser_cnt_ff + word_idx_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_op_ff   <= op_type'(req_chan.req_type);
         s1_t_ff    <= clamp_t(req_chan.param_t);
         s1_p_ff[0] <= '{x: req_chan.p0_x, y: req_chan.p0_y};
         s1_p_ff[1] <= '{x: req_chan.p1_x, y: req_chan.p1_y};
         s1_p_ff[2] <= '{x: req_chan.p2_x, y: req_chan.p2_y};
         s1_p_ff[3] <= '{x: req_chan.p3_x, y: req_chan.p3_y};
      end
      if (s2_rdy) begin
         s2_op_ff <= s1_op_ff;
         s2_t_ff  <= s1_t_ff;
         s2_p0_ff <= s1_p_ff[0];
         s2_p2_ff <= s1_p_ff[2];
         s2_p3_ff <= s1_p_ff[3];
         s2_q0_ff <= lerp_point(s1_p_ff[0], s1_p_ff[1], s1_t_ff);
         s2_q1_ff <= lerp_point(s1_p_ff[1], s1_p_ff[2], s1_t_ff);
         s2_q2_ff <= lerp_point(s1_p_ff[2], s1_p_ff[3], s1_t_ff);
      end
      if (s3_rdy) begin
         s3_op_ff <= s2_op_ff;
         s3_t_ff  <= s2_t_ff;
         s3_p0_ff <= s2_p0_ff;
         s3_p2_ff <= s2_p2_ff;
         s3_p3_ff <= s2_p3_ff;
         s3_q0_ff <= s2_q0_ff;
         s3_q1_ff <= s2_q1_ff;
         s3_q2_ff <= s2_q2_ff;
         s3_r0_ff <= lerp_point(s2_q0_ff, s2_q1_ff, s2_t_ff);
         s3_r1_ff <= lerp_point(s2_q1_ff, s2_q2_ff, s2_t_ff);
      end
      if (s4_rdy) begin
         s4_op_ff  <= s3_op_ff;
         s4_p0_ff  <= s3_p0_ff;
         s4_p2_ff  <= s3_p2_ff;
         s4_p3_ff  <= s3_p3_ff;
         s4_q0_ff  <= s3_q0_ff;
         s4_q1_ff  <= s3_q1_ff;
         s4_q2_ff  <= s3_q2_ff;
         s4_r0_ff  <= s3_r0_ff;
         s4_r1_ff  <= s3_r1_ff;
         s4_mid_ff <= lerp_point(s3_r0_ff, s3_r1_ff, s3_t_ff);
         s4_tan_ff <= s4_tan_in;
      end
      if (ser_free) begin
         ser_words_ff <= ser_words_in;
         ser_end_ff   <= ser_end_in;
      end
   end

   // quadratic tangent 2*(q1-q0), cubic 3*(r1-r0)
   assign triple = (s3_op_ff == OP_CUBIC_DERIV);
   always_comb begin
      if (triple) begin
         s4_tan_in.x = tangent_axis(s3_r0_ff.x, s3_r1_ff.x, 1'b1);
         s4_tan_in.y = tangent_axis(s3_r0_ff.y, s3_r1_ff.y, 1'b1);
      end else begin
         s4_tan_in.x = tangent_axis(s3_q0_ff.x, s3_q1_ff.x, 1'b0);
         s4_tan_in.y = tangent_axis(s3_q0_ff.y, s3_q1_ff.y, 1'b0);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_WORDS; i++) begin
         ser_words_in[i] = '0;
      end
      ser_end_in = '0;
      unique case (s4_op_ff)
         OP_QUAD_EVAL: begin
            ser_words_in[0] = make_word(s4_r0_ff, 1'b0, 2'd0);
         end
         OP_CUBIC_EVAL: begin
            ser_words_in[0] = make_word(s4_mid_ff, 1'b0, 2'd0);
         end
         OP_QUAD_DERIV, OP_CUBIC_DERIV: begin
            ser_words_in[0].x = s4_tan_ff.x;
            ser_words_in[0].y = s4_tan_ff.y;
         end
         OP_QUAD_SPLIT: begin
            ser_words_in[0] = make_word(s4_p0_ff, 1'b0, 2'd0);
            ser_words_in[1] = make_word(s4_q0_ff, 1'b0, 2'd1);
            ser_words_in[2] = make_word(s4_r0_ff, 1'b0, 2'd2);
            ser_words_in[3] = make_word(s4_r0_ff, 1'b1, 2'd0);
            ser_words_in[4] = make_word(s4_q1_ff, 1'b1, 2'd1);
            ser_words_in[5] = make_word(s4_p2_ff, 1'b1, 2'd2);
            ser_end_in      = word_idx_type'(5);
         end
         OP_CUBIC_SPLIT: begin
            ser_words_in[0] = make_word(s4_p0_ff, 1'b0, 2'd0);
            ser_words_in[1] = make_word(s4_q0_ff, 1'b0, 2'd1);
            ser_words_in[2] = make_word(s4_r0_ff, 1'b0, 2'd2);
            ser_words_in[3] = make_word(s4_mid_ff, 1'b0, 2'd3);
            ser_words_in[4] = make_word(s4_mid_ff, 1'b1, 2'd0);
            ser_words_in[5] = make_word(s4_r1_ff, 1'b1, 2'd1);
            ser_words_in[6] = make_word(s4_q2_ff, 1'b1, 2'd2);
            ser_words_in[7] = make_word(s4_p3_ff, 1'b1, 2'd3);
            ser_end_in      = word_idx_type'(7);
         end
         default: begin
            ser_end_in = '0;
         end
      endcase
   end

   assign ser_word             = ser_words_ff[ser_cnt_ff];
   assign rsp_chan.valid       = ser_vld_ff;
   assign rsp_chan.out_x       = ser_word.x;
   assign rsp_chan.out_y       = ser_word.y;
   assign rsp_chan.curve_half  = ser_word.half;
   assign rsp_chan.point_index = ser_word.index;
   assign rsp_chan.last_point  = ser_last;

endmodule

`default_nettype wire

>>> rtl/bes_checker.sv
`default_nettype none

module bes_checker
   import bes_pkg::*;
(
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_valid,
   input wire logic          rsp_ready,
   input wire out_coord_type rsp_out_x,
   input wire out_coord_type rsp_out_y,
   input wire logic          rsp_curve_half,
   input wire logic [1:0]    rsp_point_index,
   input wire logic          rsp_last_point
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y)
         && $stable(rsp_curve_half) && $stable(rsp_point_index) && $stable(rsp_last_point))
      else $error("stalled result word changed");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a split keeps streaming until its last word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_point |=> rsp_valid)
      else $error("gap inside a split");

   // point numbering inside a split, checked after each left-half word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_point && !rsp_curve_half |=>
         (!rsp_curve_half && rsp_point_index == $past(rsp_point_index) + 2'd1)
         || (rsp_curve_half && rsp_point_index == 2'd0))
      else $error("split point order broken");

endmodule

bind bezier_eval_split_unit bes_checker u_bes_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_x       (rsp_chan.out_x),
   .rsp_out_y       (rsp_chan.out_y),
   .rsp_curve_half  (rsp_chan.curve_half),
   .rsp_point_index (rsp_chan.point_index),
   .rsp_last_point  (rsp_chan.last_point)
);

`default_nettype wire

>>> tb/sv/bezier_eval_split_unit_tb.sv
`default_nettype none

module bezier_eval_split_unit_tb;
   import bes_pkg::*;

   localparam logic [2:0] OP_RSVD_6 = 3'd6;
   localparam logic [2:0] OP_RSVD_7 = 3'd7;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam int        T_ONE     = 1 << T_FRAC_BITS;

   typedef struct {
      logic [2:0] op;
      coord_type  px [4];
      coord_type  py [4];
      param_type  t;
   } curve_req_type;

   typedef struct {
      out_coord_type x;
      out_coord_type y;
      logic          half;
      logic [1:0]    index;
      logic          last;
   } curve_word_type;

   logic clock;
   logic reset;

   bes_req_if req_bus ();
   bes_rsp_if rsp_bus ();

   bezier_eval_split_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   curve_word_type pending_words [$];
   int             error_count   = 0;
   int             items_sent    = 0;
   int             words_checked = 0;
   bit             req_no_idle   = 1'b0;
   bit             rsp_no_idle   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ---------------- prediction ----------------

   function automatic longint lerp_axis(longint a, longint b, longint t);
      return a + (((b - a) * t) >>> T_FRAC_BITS);
   endfunction

   function automatic void push_word(longint x, longint y, bit half, int index, bit last);
      curve_word_type w;
      w.x     = out_coord_type'(x);
      w.y     = out_coord_type'(y);
      w.half  = half;
      w.index = 2'(index);
      w.last  = last;
      pending_words.push_back(w);
   endfunction

   function automatic void bezier_words(curve_req_type r);
      longint px [4];
      longint py [4];
      longint qx [3];
      longint qy [3];
      longint rx [2];
      longint ry [2];
      longint mx;
      longint my;
      longint t;
      for (int i = 0; i < 4; i++) begin
         px[i] = r.px[i];
         py[i] = r.py[i];
      end
      t = r.t;
      if (t <= 0) t = 0;
      if (t >= T_ONE) t = T_ONE;
      for (int i = 0; i < 3; i++) begin
         qx[i] = lerp_axis(px[i], px[i+1], t);
         qy[i] = lerp_axis(py[i], py[i+1], t);
      end
      for (int i = 0; i < 2; i++) begin
         rx[i] = lerp_axis(qx[i], qx[i+1], t);
         ry[i] = lerp_axis(qy[i], qy[i+1], t);
      end
      mx = lerp_axis(rx[0], rx[1], t);
      my = lerp_axis(ry[0], ry[1], t);
      case (r.op)
         OP_QUAD_EVAL: begin
            push_word(rx[0], ry[0], 0, 0, 1);
         end
         OP_QUAD_DERIV: begin
            push_word(2 * (qx[1] - qx[0]), 2 * (qy[1] - qy[0]), 0, 0, 1);
         end
         OP_QUAD_SPLIT: begin
            push_word(px[0], py[0], 0, 0, 0);
            push_word(qx[0], qy[0], 0, 1, 0);
            push_word(rx[0], ry[0], 0, 2, 0);
            push_word(rx[0], ry[0], 1, 0, 0);
            push_word(qx[1], qy[1], 1, 1, 0);
            push_word(px[2], py[2], 1, 2, 1);
         end
         OP_CUBIC_EVAL: begin
            push_word(mx, my, 0, 0, 1);
         end
         OP_CUBIC_DERIV: begin
            push_word(3 * (rx[1] - rx[0]), 3 * (ry[1] - ry[0]), 0, 0, 1);
         end
         OP_CUBIC_SPLIT: begin
            push_word(px[0], py[0], 0, 0, 0);
            push_word(qx[0], qy[0], 0, 1, 0);
            push_word(rx[0], ry[0], 0, 2, 0);
            push_word(mx, my, 0, 3, 0);
            push_word(mx, my, 1, 0, 0);
            push_word(rx[1], ry[1], 1, 1, 0);
            push_word(qx[2], qy[2], 1, 2, 0);
            push_word(px[3], py[3], 1, 3, 1);
         end
         default: begin
            // reserved codes produce no words
         end
      endcase
   endfunction

   // ---------------- result side ----------------

   initial begin
      int stall;
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         stall = rsp_no_idle ? 0 : idle_cycles();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   function automatic void check_field(string name, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_words
      curve_word_type exp_w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected word: out_x %0d out_y %0d", rsp_bus.out_x, rsp_bus.out_y);
            error_count++;
         end else begin
            exp_w = pending_words.pop_front();
            check_field("out_x", exp_w.x, rsp_bus.out_x);
            check_field("out_y", exp_w.y, rsp_bus.out_y);
            check_field("curve_half", {63'd0, exp_w.half}, {63'd0, rsp_bus.curve_half});
            check_field("point_index", {62'd0, exp_w.index}, {62'd0, rsp_bus.point_index});
            check_field("last_point", {63'd0, exp_w.last}, {63'd0, rsp_bus.last_point});
         end
         words_checked++;
      end
   end

   // ---------------- request side ----------------

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return coord_type'($urandom_range(0, 2047)) - coord_type'(1024);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic param_type rand_param();
      case ($urandom_range(0, 9))
         0: return param_type'($urandom);
         1: return param_type'(0);
         2: return param_type'(T_ONE);
         default: return param_type'($urandom_range(0, T_ONE));
      endcase
   endfunction

   function automatic curve_req_type random_req(logic [2:0] op);
      curve_req_type r;
      r.op = op;
      for (int i = 0; i < 4; i++) begin
         r.px[i] = rand_coord();
         r.py[i] = rand_coord();
      end
      r.t = rand_param();
      return r;
   endfunction

   function automatic logic [2:0] random_op();
      if ($urandom_range(0, 99) < 5) return ($urandom_range(0, 1) != 0) ? OP_RSVD_7 : OP_RSVD_6;
      return 3'($urandom_range(0, 5));
   endfunction

   // returns at the edge where the word was taken
   task automatic send_request(input curve_req_type r);
      int gap;
      gap = req_no_idle ? 0 : idle_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= r.op;
      req_bus.p0_x     <= r.px[0];
      req_bus.p0_y     <= r.py[0];
      req_bus.p1_x     <= r.px[1];
      req_bus.p1_y     <= r.py[1];
      req_bus.p2_x     <= r.px[2];
      req_bus.p2_y     <= r.py[2];
      req_bus.p3_x     <= r.px[3];
      req_bus.p3_y     <= r.py[3];
      req_bus.param_t  <= r.t;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bezier_words(r);
      items_sent++;
   endtask

   // ---------------- tests ----------------

   task automatic test_operation_extremes();
      curve_req_type r;
      for (int op = 0; op < 6; op++) begin
         r = random_req(3'(op));
         for (int i = 0; i < 4; i++) begin
            r.px[i] = (i % 2 == 0) ? COORD_MIN : COORD_MAX;
            r.py[i] = (i % 2 == 0) ? COORD_MAX : COORD_MIN;
         end
         r.t = param_type'(T_ONE / 2);
         send_request(r);
      end
      r = random_req(OP_CUBIC_SPLIT);
      for (int i = 0; i < 4; i++) begin
         r.px[i] = COORD_MAX;
         r.py[i] = COORD_MIN;
      end
      r.t = param_type'(T_ONE - 1);
      send_request(r);
   endtask

   task automatic test_param_clamp();
      curve_req_type r;
      param_type     t_list [8];
      t_list = '{param_type'(-(1 << (T_BITS-1))), param_type'(-1), param_type'(0),
                 param_type'(1), param_type'(T_ONE - 1), param_type'(T_ONE),
                 param_type'(T_ONE + 1), param_type'((1 << (T_BITS-1)) - 1)};
      for (int i = 0; i < 8; i++) begin
         r = random_req((i % 2 == 0) ? OP_CUBIC_SPLIT : 3'(i % 6));
         r.t = t_list[i];
         send_request(r);
      end
   endtask

   task automatic test_reserved_ops();
      send_request(random_req(OP_RSVD_6));
      send_request(random_req(OP_RSVD_7));
   endtask

   task automatic test_random_mix(int count);
      for (int i = 0; i < count; i++) send_request(random_req(random_op()));
   endtask

   // full rate on both sides so the stages stack up behind splits
   task automatic test_back_to_back(int count);
      req_no_idle = 1'b1;
      rsp_no_idle = 1'b1;
      for (int i = 0; i < count; i++) send_request(random_req(random_op()));
      req_no_idle = 1'b0;
      rsp_no_idle = 1'b0;
   endtask

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= OP_QUAD_EVAL;
      req_bus.p0_x     <= '0;
      req_bus.p0_y     <= '0;
      req_bus.p1_x     <= '0;
      req_bus.p1_y     <= '0;
      req_bus.p2_x     <= '0;
      req_bus.p2_y     <= '0;
      req_bus.p3_x     <= '0;
      req_bus.p3_y     <= '0;
      req_bus.param_t  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_operation_extremes();
      test_param_clamp();
      test_reserved_ops();
      test_random_mix(50);
      test_back_to_back(30);
      test_random_mix(13);

      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d requests: every operation, coordinate and parameter limits,",
               items_sent);
      $display("reserved codes and random stalls; %0d result words checked.", words_checked);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
